// File: sv/ems_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ems_pkg: shared definitions for the MAC address swap block
// Header geometry, queue sizing and the command that passes from the
// classifying front end to the executing back end.
// ----------------------------------------------------------------------------
package ems_pkg;

	localparam int unsigned ADDRESS_BYTES = 6;
	localparam int unsigned HDR_BYTES     = 2 * ADDRESS_BYTES;
	localparam int unsigned HDR_IDX_W     = (HDR_BYTES > 1) ? $clog2(HDR_BYTES) : 1;

	localparam logic [HDR_IDX_W-1:0] ADDR_OFS = HDR_IDX_W'(ADDRESS_BYTES);
	localparam logic [HDR_IDX_W-1:0] LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_CAPTURE,
		OP_SEND,
		OP_STREAM
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [HDR_IDX_W-1:0] idx;
		logic [7:0]           data;
		logic                 last;
	} cmd_t;

endpackage
`default_nettype wire

// File: sv/ethernet_mac_address_swap.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_mac_address_swap: loopback header rewrite
// Returns each Ethernet frame with its destination and source MAC addresses
// exchanged, one byte per beat.
// ----------------------------------------------------------------------------
// The block takes one frame byte per beat and normally accepts a beat every
// clock cycle. The first twelve bytes of a frame (both MAC addresses) are
// only stored. Each of the next twelve bytes goes into a twelve-entry delay
// ring and releases one header byte, the source address first and then the
// destination address; after that every byte leaves the ring twelve beats
// after it entered, so the output trails the input by twelve bytes. The beat
// that carries frame_end releases one byte and then the back end drains the
// twelve bytes left in the ring, one per cycle while the output is free; the
// last of them carries out_end. During that drain the four-entry command
// queue between the classifier and the executor fills, after which in_stall
// rises and holds the input off until the back end pops the first queued
// command after the drain. Otherwise the rate is one byte per cycle while
// the output is free, set by the back end, which carries out one command per
// cycle. Frames must be at least 25 bytes long; a frame end inside the
// address capture is ignored, and one inside the header send is kept with
// its byte and simply shows up on the output when that byte leaves.
// out_stall may be held for any time; the output register holds its beat and
// the queue lets the input run on until it is full.
// ----------------------------------------------------------------------------
module ethernet_mac_address_swap
	import ems_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            out_end
);

	// Command path from classifier through the queue to the executor.
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_valid;
	cmd_t head;
	logic pop;

	ems_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.q_full    (q_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	ems_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.q_valid  (q_valid),
		.head     (head)
	);

	ems_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_end   (out_end)
	);

endmodule
`default_nettype wire

// File: sv/ems_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ems_front: input beat classifier
// Tracks the frame phase and turns each input beat into a command for the
// back end: header capture, header send with store index, or streaming.
// ----------------------------------------------------------------------------
module ems_front
	import ems_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	input  wire logic       q_full,
	output logic            push,
	output cmd_t            cmd
);

	typedef enum logic [1:0] {
		PH_CAPTURE,
		PH_SEND,
		PH_STREAM
	} phase_t;

	phase_t               phase_q;
	logic [HDR_IDX_W-1:0] count_q;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		cmd.data = data_byte;
		cmd.last = frame_end;
		cmd.idx  = count_q;
		cmd.op   = OP_CAPTURE;
		unique case (phase_q)
			PH_CAPTURE: cmd.op = OP_CAPTURE;
			PH_SEND: begin
				cmd.op  = OP_SEND;
				// Source address goes out first, then the destination.
				cmd.idx = (count_q < ADDR_OFS) ? count_q + ADDR_OFS : count_q - ADDR_OFS;
			end
			PH_STREAM: cmd.op = OP_STREAM;
			default: cmd.op = OP_CAPTURE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CAPTURE;
			count_q <= '0;
		end else if (push) begin
			unique case (phase_q)
				PH_CAPTURE: begin
					if (count_q == LAST_IDX) begin
						count_q <= '0;
						phase_q <= PH_SEND;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				PH_SEND: begin
					if (count_q == LAST_IDX) begin
						count_q <= '0;
						phase_q <= PH_STREAM;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end
				PH_STREAM: begin
					if (frame_end) begin
						phase_q <= PH_CAPTURE;
						count_q <= '0;
					end
				end
				default: begin
					phase_q <= PH_CAPTURE;
					count_q <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/ems_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ems_queue: command queue
// Small first-in first-out buffer that decouples the classifier from the
// executing back end.
// ----------------------------------------------------------------------------
module ems_queue
	import ems_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      q_valid,
	output cmd_t      head
);

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   fill_q;

	assign full    = (fill_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign q_valid = (fill_q != '0);
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/ems_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ems_back: command executor
// Holds the header store and the delay ring, runs the end-of-frame drain
// and drives the registered output channel.
// ----------------------------------------------------------------------------
module ems_back
	import ems_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire cmd_t head,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [7:0] out_byte,
	output logic      out_end
);

	logic [7:0]           hdr_q  [HDR_BYTES];
	logic [8:0]           ring_q [HDR_BYTES];
	logic [HDR_IDX_W-1:0] ptr_q;
	logic [HDR_IDX_W-1:0] drain_cnt_q;
	logic                 draining_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_end_q;

	logic                 out_free;
	logic                 load;
	logic [8:0]           load_item;
	logic                 hdr_we;
	logic                 ring_we;
	logic [HDR_IDX_W-1:0] ptr_inc;
	logic                 drain_last;

	assign out_free   = !out_valid_q || !out_stall;
	assign ptr_inc    = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
	assign drain_last = (drain_cnt_q == LAST_IDX);

	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		load_item = ring_q[ptr_q];
		hdr_we    = 1'b0;
		ring_we   = 1'b0;
		if (draining_q) begin
			load = out_free;
		end else if (q_valid) begin
			unique case (head.op)
				OP_CAPTURE: begin
					pop    = 1'b1;
					hdr_we = 1'b1;
				end
				OP_SEND: begin
					pop       = out_free;
					load      = out_free;
					ring_we   = out_free;
					load_item = {1'b0, hdr_q[head.idx]};
				end
				OP_STREAM: begin
					pop     = out_free;
					load    = out_free;
					ring_we = out_free;
				end
				default: pop = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_q[head.idx] <= head.data;
		end
		if (ring_we) begin
			ring_q[ptr_q] <= {head.last, head.data};
		end
		if (load) begin
			out_byte_q <= load_item[7:0];
			out_end_q  <= load_item[8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			drain_cnt_q <= '0;
			draining_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (draining_q) begin
				if (out_free) begin
					if (drain_last) begin
						draining_q  <= 1'b0;
						drain_cnt_q <= '0;
						ptr_q       <= '0;
					end else begin
						drain_cnt_q <= drain_cnt_q + 1'b1;
						ptr_q       <= ptr_inc;
					end
				end
			end else if (ring_we) begin
				ptr_q <= ptr_inc;
				if (head.op == OP_STREAM && head.last) begin
					draining_q  <= 1'b1;
					drain_cnt_q <= '0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_end   = out_end_q;

	a_no_pop_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> !pop)
		else $error("command popped during ring drain");

	a_drain_ends_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(draining_q && drain_last && out_free) |=> (ptr_q == '0 && !draining_q))
		else $error("ring pointer not rewound after drain");

	a_capture_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		(!draining_q && q_valid && head.op == OP_CAPTURE) |-> !load)
		else $error("header capture produced an output beat");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q <= LAST_IDX) && (drain_cnt_q <= LAST_IDX))
		else $error("ring pointer or drain count out of range");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the MAC address swap block
// Drives Ethernet frames into the block one byte per beat, predicts the
// rewritten frames with a scoreboard, and compares every output beat.
// ----------------------------------------------------------------------------
// A directed frame of minimum length comes first. It carries extreme byte
// values and has stray ends in the capture and send phases. Random frames
// follow, mostly well formed with random contents and some stray header ends.
// Both sides insert random idle bursts. At one point the receiver holds
// off long enough that the block backs up and stalls its input. The last
// part of the run goes at full rate with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;
	import ems_pkg::*;

	// Period is 10 units. The run limit lies far above the time that the
	// slowest correct run needs, with every stall burst at its longest.
	localparam longint unsigned RUN_LIMIT    = 64'd2_000_000;
	localparam int unsigned     RANDOM_ITEMS = 75;
	localparam int unsigned     HOLD_CYCLES  = 150;
	localparam int unsigned     TAIL_CYCLES  = 40;
	localparam int unsigned     PRINT_CAP    = 200;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} swap_beat_t;

	// The scoreboard keeps its own copy of the header store, the delay ring
	// and the frame phase. For each input beat it queues the output beats
	// that the beat releases.
	class swap_scoreboard;
		logic [7:0]  addr_store [HDR_BYTES];
		logic [8:0]  delay_line [HDR_BYTES];
		op_t         stage;
		int unsigned hdr_count;
		int unsigned slot;
		swap_beat_t  expected_beats [$];
		int unsigned errors;
		int unsigned beats_in;
		int unsigned beats_out;
		int unsigned ends_out;

		function new();
			stage     = OP_CAPTURE;
			hdr_count = 0;
			slot      = 0;
			errors    = 0;
			beats_in  = 0;
			beats_out = 0;
			ends_out  = 0;
		endfunction

		function void queue_beat(logic [8:0] entry);
			swap_beat_t b;
			b.data = entry[7:0];
			b.last = entry[8];
			expected_beats.push_back(b);
		endfunction

		function void step_slot();
			slot = (slot + 1 >= HDR_BYTES) ? 0 : slot + 1;
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void note_beat(logic [7:0] data, logic last);
			logic [8:0]  entry;
			int unsigned i;
			entry = {last, data};
			beats_in++;
			case (stage)
				OP_CAPTURE: begin
					// A frame end seen here is dropped on the floor.
					addr_store[hdr_count] = data;
					hdr_count++;
					if (hdr_count >= HDR_BYTES) begin
						hdr_count = 0;
						slot      = 0;
						stage     = OP_SEND;
					end
				end
				OP_SEND: begin
					// The end flag goes into the ring with its byte, but no drain starts.
					delay_line[slot] = entry;
					step_slot();
					queue_beat({1'b0, addr_store[(hdr_count + ADDRESS_BYTES) % HDR_BYTES]});
					hdr_count++;
					if (hdr_count >= HDR_BYTES) begin
						hdr_count = 0;
						slot      = 0;
						stage     = OP_STREAM;
					end
				end
				OP_STREAM: begin
					queue_beat(delay_line[slot]);
					delay_line[slot] = entry;
					step_slot();
					if (last) begin
						for (i = 0; i < HDR_BYTES; i++) begin
							queue_beat(delay_line[slot]);
							step_slot();
						end
						stage     = OP_CAPTURE;
						hdr_count = 0;
						slot      = 0;
					end
				end
				default: begin
					stage     = OP_CAPTURE;
					hdr_count = 0;
					slot      = 0;
				end
			endcase
		endfunction

		task check_beat(logic [7:0] data, logic last);
			swap_beat_t want;
			beats_out++;
			if (last === 1'b1)
				ends_out++;
			if (expected_beats.size() == 0) begin
				report($sformatf("output beat %02h end %0b with nothing expected", data, last));
				return;
			end
			want = expected_beats.pop_front();
			if (data !== want.data)
				report($sformatf("out_byte %02h, expected %02h", data, want.data));
			if (last !== want.last)
				report($sformatf("out_end %0b, expected %0b", last, want.last));
		endtask

		function int unsigned pending();
			return expected_beats.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       frame_end;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       out_end;

	swap_scoreboard sb;

	// Flags shared between the stimulus and the receiver process, and the count of frames sent.
	bit          quiet_tail;
	bit          hold_request;
	int unsigned frames_sent;

	// The directed frame holds extreme and alternating bit patterns. Byte 4
	// carries a frame end during address capture, and byte 15 carries one
	// during the header send. The real frame end is on byte 24.
	logic [7:0] directed_bytes [25] = '{
		8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h7F, 8'hFE, 8'h0F, 8'hF0,
		8'h33, 8'hCC, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF1,
		8'h5A, 8'hA5, 8'hC3, 8'h3C, 8'hE7
	};

	ethernet_mac_address_swap u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_end   (out_end)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Both channels are observed at the rising edge, where the values that
	// settled after the previous falling edge are seen. The input is noted
	// before the output is checked, so the order of the two does not matter.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_beat(data_byte, frame_end);
		if (arst_n && out_valid && !out_stall)
			sb.check_beat(out_byte, out_end);
	end

	// Offer one beat and hold it until the block takes it. A random idle
	// burst may come first, and during that burst the data lines carry junk
	// with valid low.
	task automatic send_beat(input logic [7:0] b, input logic e);
		int unsigned gap;
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid  <= 1'b0;
			data_byte <= 8'($urandom_range(0, 255));
			frame_end <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		frame_end <= e;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Send a frame of random bytes with its end on the last byte. A stray end
	// may also be placed inside the header, where the block either drops it
	// or carries it along.
	task automatic send_frame(input int len, input int stray);
		int i;
		for (i = 0; i < len; i++)
			send_beat(8'($urandom_range(0, 255)), (i == len - 1) || (i == stray));
		frames_sent++;
	endtask

	// Receiver. It mostly accepts, stalls in random bursts, and once holds off
	// for a long counted stretch so that the block fills and stalls its input.
	initial begin
		int unsigned burst;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
				burst = $urandom_range(1, 9);
				out_stall <= 1'b1;
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int i;
		int len;
		int stray;
		int unsigned random_beats;
		sb           = new();
		quiet_tail   = 1'b0;
		hold_request = 1'b0;
		frames_sent  = 0;
		random_beats = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = 8'h00;
		frame_end    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < 25; i++)
			send_beat(directed_bytes[i], (i == 4) || (i == 15) || (i == 24));
		frames_sent++;

		// Random frames are mostly near minimum length, with some long ones so that
		// the ring pointer wraps up to three times inside the payload.
		while (random_beats < RANDOM_ITEMS) begin
			if (random_beats >= (RANDOM_ITEMS * 3) / 4)
				quiet_tail = 1'b1;
			if (frames_sent == 2)
				hold_request = 1'b1;
			len   = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 64) : $urandom_range(25, 40);
			stray = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * HDR_BYTES - 1) : -1;
			send_frame(len, stray);
			random_beats += len;
		end

		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d output beats never arrived", sb.pending()));

		$display("Sent %0d input beats in %0d frames, with stray header ends and a %0d-cycle hold.",
			sb.beats_in, frames_sent, HOLD_CYCLES);
		$display("Checked %0d output beats carrying %0d frame ends; %0d mismatches.",
			sb.beats_out, sb.ends_out, sb.errors);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Run limit reached with %0d output beats still expected.", sb.pending());
		$display("== FAIL ==");
		$finish;
	end

endmodule
